// ===== hdl/ppd_pkg.sv =====
// Shared types and constants for the partial Pearson distance block.
`default_nettype none
package ppd_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int MAX_SAMPLES = 4096;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_SAMPLES);
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int SQ_SUM_W    = PROD_W + $clog2(MAX_SAMPLES);
   localparam int MUL_W       = CNT_W + SQ_SUM_W;
   localparam int MP_W        = 2 * MUL_W;
   localparam int SCALE_BITS  = 60;
   localparam int QUO_W       = SCALE_BITS + 2;
   localparam int DIV_SHIFT   = QUO_W - SCALE_BITS;
   localparam int ROOT_W      = SCALE_BITS + 1;
   localparam int SQRT_STEPS  = (ROOT_W + 1) / 2;
   localparam int STEP_CNT_W  = $clog2(MUL_W + 1);

   localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
   localparam logic [31:0] DIST_MAX = 32'h8000_0000;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TOO_FEW    = 2'd1,
      STATUS_DEGENERATE = 2'd2
   } status_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x_sample;
      logic [SAMPLE_BITS-1:0] y_sample;
      logic                   last_sample;
   } ppd_req_type;

   typedef struct packed {
      logic [31:0]      distance;
      status_type       status;
      logic [CNT_W-1:0] observed_pairs;
   } ppd_rsp_type;

   // Operand pairs fed to the shared multiplier, in the order they are used.
   typedef enum logic [2:0] {
      MSEL_N_XX = 3'd0,
      MSEL_X_X  = 3'd1,
      MSEL_N_YY = 3'd2,
      MSEL_Y_Y  = 3'd3,
      MSEL_V_V  = 3'd4,
      MSEL_N_XY = 3'd5,
      MSEL_X_Y  = 3'd6,
      MSEL_C_C  = 3'd7
   } mul_sel_type;

   typedef struct packed {
      logic        acc_clear;
      logic        mul_load;
      mul_sel_type mul_sel;
      logic        mul_step;
      logic        save_a;
      logic        save_vx;
      logic        save_vy;
      logic        save_den;
      logic        save_c;
      logic        div_load;
      logic        div_step;
      logic        sqrt_load;
      logic        sqrt_step;
      logic        out_load;
      status_type  out_status;
   } ppd_cmd_type;

   typedef struct packed {
      logic last_acc;
      logic too_few;
      logic degenerate;
   } ppd_stat_type;

endpackage
`default_nettype wire

// ===== hdl/ppd_dp.sv =====
// Datapath: sample pipeline, accumulators, serial multiplier, divider and square root.
`default_nettype none
module ppd_dp
   import ppd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire ppd_req_type  in_data,
   input  wire ppd_cmd_type  cmd,
   output ppd_stat_type      stat,
   output ppd_rsp_type       out_data
);

   // sample pipeline
   logic                   s1_valid_ff, s1_last_ff;
   logic [SAMPLE_BITS-1:0] s1_x_ff, s1_y_ff;
   logic                   s2_valid_ff, s2_last_ff;
   logic [SAMPLE_BITS-1:0] s2_x_ff, s2_y_ff;
   logic [PROD_W-1:0]      s2_xy_ff, s2_xx_ff, s2_yy_ff;

   logic [SUM_W-1:0]       acc_x_ff, acc_y_ff;
   logic [SQ_SUM_W-1:0]    acc_xy_ff, acc_xx_ff, acc_yy_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   use_pair;

   // finishing arithmetic
   logic [MUL_W-1:0]       mul_a_ff, mul_b_ff, mul_a_in, mul_b_in;
   logic [MP_W-1:0]        mp_ff;
   logic [MUL_W-1:0]       mp_low;
   logic [MUL_W-1:0]       ta_ff, vx_ff, vy_ff, c_ff;
   logic                   neg_ff;
   logic [MP_W-1:0]        den_ff, rem_ff;
   logic [MP_W:0]          rem_shift;
   logic [QUO_W-1:0]       num_lo_ff, quo_ff;
   logic [ROOT_W-1:0]      sq_v_ff, sq_res_ff, sq_bit_ff, sq_trial;
   logic [31:0]            root32, dist_ok;
   ppd_rsp_type            rsp_ff;

   assign use_pair = s2_valid_ff && (s2_y_ff != '0) &&
                     (count_ff < CNT_W'(MAX_SAMPLES));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_x_ff    <= in_data.x_sample;
      s1_y_ff    <= in_data.y_sample;
      s1_last_ff <= in_data.last_sample;
      s2_x_ff    <= s1_x_ff;
      s2_y_ff    <= s1_y_ff;
      s2_last_ff <= s1_last_ff;
      s2_xy_ff   <= PROD_W'(s1_x_ff) * PROD_W'(s1_y_ff);
      s2_xx_ff   <= PROD_W'(s1_x_ff) * PROD_W'(s1_x_ff);
      s2_yy_ff   <= PROD_W'(s1_y_ff) * PROD_W'(s1_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.acc_clear) begin
         acc_x_ff  <= '0;
         acc_y_ff  <= '0;
         acc_xy_ff <= '0;
         acc_xx_ff <= '0;
         acc_yy_ff <= '0;
         count_ff  <= '0;
      end else if (use_pair) begin
         acc_x_ff  <= acc_x_ff + SUM_W'(s2_x_ff);
         acc_y_ff  <= acc_y_ff + SUM_W'(s2_y_ff);
         acc_xy_ff <= acc_xy_ff + SQ_SUM_W'(s2_xy_ff);
         acc_xx_ff <= acc_xx_ff + SQ_SUM_W'(s2_xx_ff);
         acc_yy_ff <= acc_yy_ff + SQ_SUM_W'(s2_yy_ff);
         count_ff  <= count_ff + 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.mul_sel)
         MSEL_N_XX: begin mul_a_in = MUL_W'(count_ff); mul_b_in = MUL_W'(acc_xx_ff); end
         MSEL_X_X:  begin mul_a_in = MUL_W'(acc_x_ff); mul_b_in = MUL_W'(acc_x_ff);  end
         MSEL_N_YY: begin mul_a_in = MUL_W'(count_ff); mul_b_in = MUL_W'(acc_yy_ff); end
         MSEL_Y_Y:  begin mul_a_in = MUL_W'(acc_y_ff); mul_b_in = MUL_W'(acc_y_ff);  end
         MSEL_V_V:  begin mul_a_in = vx_ff;            mul_b_in = vy_ff;             end
         MSEL_N_XY: begin mul_a_in = MUL_W'(count_ff); mul_b_in = MUL_W'(acc_xy_ff); end
         MSEL_X_Y:  begin mul_a_in = MUL_W'(acc_x_ff); mul_b_in = MUL_W'(acc_y_ff);  end
         MSEL_C_C:  begin mul_a_in = c_ff;             mul_b_in = c_ff;              end
         default:   begin mul_a_in = '0;               mul_b_in = '0;                end
      endcase
   end

   assign mp_low    = mp_ff[MUL_W-1:0];
   assign rem_shift = {rem_ff, num_lo_ff[QUO_W-1]};
   assign sq_trial  = sq_res_ff + sq_bit_ff;

   // msb-first shift-add multiply, one operand bit per step
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mul_a_ff <= mul_a_in;
         mul_b_ff <= mul_b_in;
         mp_ff    <= '0;
      end else if (cmd.mul_step) begin
         mp_ff    <= {mp_ff[MP_W-2:0], 1'b0} +
                     (mul_b_ff[MUL_W-1] ? MP_W'(mul_a_ff) : '0);
         mul_b_ff <= {mul_b_ff[MUL_W-2:0], 1'b0};
      end
      if (cmd.save_a) ta_ff <= mp_low;
      if (cmd.save_vx) vx_ff <= (ta_ff > mp_low) ? ta_ff - mp_low : '0;
      if (cmd.save_vy) vy_ff <= (ta_ff > mp_low) ? ta_ff - mp_low : '0;
      if (cmd.save_den) den_ff <= mp_ff;
      if (cmd.save_c) begin
         neg_ff <= ta_ff < mp_low;
         c_ff   <= (ta_ff < mp_low) ? mp_low - ta_ff : ta_ff - mp_low;
      end
   end

   // restoring divide of (c*c << 60) by the variance product
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff    <= MP_W'(mp_ff[MP_W-1:DIV_SHIFT]);
         num_lo_ff <= {mp_ff[DIV_SHIFT-1:0], {SCALE_BITS{1'b0}}};
         quo_ff    <= '0;
      end else if (cmd.div_step) begin
         num_lo_ff <= {num_lo_ff[QUO_W-2:0], 1'b0};
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_ff <= MP_W'(rem_shift - {1'b0, den_ff});
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[MP_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   // digit-by-digit square root, two radicand bits per step
   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         sq_v_ff   <= (quo_ff > (QUO_W'(1) << SCALE_BITS)) ?
                      (ROOT_W'(1) << SCALE_BITS) : quo_ff[ROOT_W-1:0];
         sq_res_ff <= '0;
         sq_bit_ff <= ROOT_W'(1) << SCALE_BITS;
      end else if (cmd.sqrt_step) begin
         if (sq_v_ff >= sq_trial) begin
            sq_v_ff   <= sq_v_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   assign root32  = (sq_res_ff > ROOT_W'(Q30_ONE)) ? Q30_ONE : sq_res_ff[31:0];
   assign dist_ok = neg_ff ? Q30_ONE + root32 : Q30_ONE - root32;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.distance       <= (cmd.out_status == STATUS_OK) ? dist_ok : DIST_MAX;
         rsp_ff.status         <= cmd.out_status;
         rsp_ff.observed_pairs <= count_ff;
      end
   end

   assign out_data        = rsp_ff;
   assign stat.last_acc   = s2_valid_ff && s2_last_ff;
   assign stat.too_few    = count_ff < CNT_W'(2);
   assign stat.degenerate = (vx_ff == '0) || (vy_ff == '0);

endmodule
`default_nettype wire

// ===== hdl/ppd_ctrl.sv =====
// Controller: sequences accumulation, finishing arithmetic and result handoff.
`default_nettype none
module ppd_ctrl
   import ppd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   input  wire logic          rsp_ready,
   input  wire ppd_stat_type  stat,
   output logic               req_ready,
   output logic               rsp_valid,
   output ppd_cmd_type        cmd
);

   typedef enum logic [3:0] {
      ST_ACCUM, ST_CHECK, ST_MLOAD, ST_MRUN, ST_MSAVE, ST_DEGEN,
      ST_DLOAD, ST_DRUN, ST_SLOAD, ST_SRUN, ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   mul_sel_type            phase_ff, phase_in;
   logic [STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   status_type             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pending_ff, pending_in;
   logic                   req_fire;

   assign req_ready = (state_ff == ST_ACCUM) && !pending_ff;
   assign rsp_valid = rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cmd            = '0;
      cmd.mul_sel    = phase_ff;
      cmd.out_status = status_ff;
      state_in       = state_ff;
      phase_in       = phase_ff;
      cnt_in         = cnt_ff;
      status_in      = status_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (stat.last_acc) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.too_few) begin
               status_in = STATUS_TOO_FEW;
               state_in  = ST_OUT;
            end else begin
               phase_in = MSEL_N_XX;
               state_in = ST_MLOAD;
            end
         end
         ST_MLOAD: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_MRUN;
         end
         ST_MRUN: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(MUL_W - 1)) state_in = ST_MSAVE;
         end
         ST_MSAVE: begin
            phase_in = mul_sel_type'(phase_ff + 1'b1);
            state_in = ST_MLOAD;
            unique case (phase_ff)
               MSEL_N_XX: cmd.save_a   = 1'b1;
               MSEL_X_X:  cmd.save_vx  = 1'b1;
               MSEL_N_YY: cmd.save_a   = 1'b1;
               MSEL_Y_Y: begin
                  cmd.save_vy = 1'b1;
                  state_in    = ST_DEGEN;
               end
               MSEL_V_V:  cmd.save_den = 1'b1;
               MSEL_N_XY: cmd.save_a   = 1'b1;
               MSEL_X_Y:  cmd.save_c   = 1'b1;
               MSEL_C_C:  state_in     = ST_DLOAD;
               default:   state_in     = ST_DLOAD;
            endcase
         end
         ST_DEGEN: begin
            if (stat.degenerate) begin
               status_in = STATUS_DEGENERATE;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_MLOAD;
            end
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DRUN;
         end
         ST_DRUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(QUO_W - 1)) state_in = ST_SLOAD;
         end
         ST_SLOAD: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SRUN;
         end
         ST_SRUN: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(SQRT_STEPS - 1)) begin
               status_in = STATUS_OK;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load  = 1'b1;
               cmd.acc_clear = 1'b1;
               state_in      = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase

      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      pending_in   = cmd.out_load ? 1'b0 : (pending_ff || (req_fire && req_last));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         phase_ff     <= MSEL_N_XX;
         cnt_ff       <= '0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

`ifndef SYNTHESIS
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("request accepted after a last request");
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MRUN) |-> (cnt_ff < STEP_CNT_W'(MUL_W)))
      else $error("multiplier step count overrun");
   a_check_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> $past(stat.last_acc))
      else $error("finish started without a last request");
`endif

endmodule
`default_nettype wire

// ===== hdl/partial_pearson_distance_top.sv =====
// Top level of the streamed partial Pearson correlation distance block.
// Result path: a last request's result is loaded after the finishing sequence, which stops
// early with fewer than two pairs (no multiply) or zero variance (after four multiplies).
// Throughput: one request per cycle within a profile; after a last request no request
// is taken until the result is loaded, set by the bit-serial multiplier, divider and root.
// Reset: synchronous, active high; clears all sums, the pair count and handshakes.
`default_nettype none
module partial_pearson_distance_top
   import ppd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ppd_req_type  req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ppd_rsp_type       rsp_payload
);

   ppd_cmd_type  cmd;
   ppd_stat_type stat;

   // Controller: lets requests stream in, then walks the finishing sequence
   // (eight serial multiplies, one divide, one square root) per profile, cut short on too few pairs or zero variance.
   ppd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_sample),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Datapath: two-stage product pipeline into the sums, then the shared
   // arithmetic units and the result register.
   ppd_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid && req_ready),
      .in_data  (req_payload),
      .cmd      (cmd),
      .stat     (stat),
      .out_data (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== test/partial_pearson_distance_top_test.sv =====
// Self-checking testbench for the streamed partial Pearson distance block.
`default_nettype none
module partial_pearson_distance_top_test;
   import ppd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ppd_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   ppd_rsp_type rsp_payload;

   partial_pearson_distance_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // Predictor state: running sums over the observed pairs of the open profile.
   logic [SUM_W-1:0]    sum_x, sum_y;
   logic [SQ_SUM_W-1:0] sum_xy, sum_xx, sum_yy;
   int unsigned         pair_total;

   ppd_rsp_type distance_queue[$];

   int  error_count;
   int  request_count;
   int  result_count;
   bit  idle_enable;       // random gaps and stalls on both sides
   int  hold_len;          // long receiver hold-off, picked up by the ready process
   int  hold_left;
   int  stall_left;

   // Clock generator; the single reset at the start of the run comes from the main initial block.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Global limit; the slowest legal run is far below this.
   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %0d, expected %0d (result %0d)",
               what, got, want, result_count);
      error_count++;
   endtask

   // Integer square root, bit pair at a time, truncated.
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic ppd_rsp_type profile_distance();
      ppd_rsp_type r;
      logic [255:0] n, a, b, var_x, var_y, den, cov, quo;
      logic [63:0]  q, root;
      bit           neg;
      r.distance       = DIST_MAX;
      r.observed_pairs = pair_total[CNT_W-1:0];
      if (pair_total < 2) begin
         r.status = STATUS_TOO_FEW;
         return r;
      end
      n = 256'(pair_total);
      a = n * sum_xx;
      b = 256'(sum_x) * sum_x;
      var_x = (a > b) ? a - b : '0;
      a = n * sum_yy;
      b = 256'(sum_y) * sum_y;
      var_y = (a > b) ? a - b : '0;
      if (var_x == 0 || var_y == 0) begin
         r.status = STATUS_DEGENERATE;
         return r;
      end
      den = var_x * var_y;
      a   = n * sum_xy;
      b   = 256'(sum_x) * sum_y;
      neg = a < b;
      cov = neg ? b - a : a - b;
      quo = ((cov * cov) << SCALE_BITS) / den;
      q   = (quo > (256'd1 << SCALE_BITS)) ? (64'd1 << SCALE_BITS) : quo[63:0];
      root = root_floor(q);
      if (root > Q30_ONE) root = Q30_ONE;
      r.distance = neg ? Q30_ONE + root[31:0] : Q30_ONE - root[31:0];
      r.status   = STATUS_OK;
      return r;
   endfunction

   // Fold one accepted request into the sums; a last request closes the profile.
   task automatic track_request(input ppd_req_type p);
      logic [SQ_SUM_W-1:0] x, y;
      x = SQ_SUM_W'(p.x_sample);
      y = SQ_SUM_W'(p.y_sample);
      if (y != 0 && pair_total < MAX_SAMPLES) begin
         sum_x  += SUM_W'(p.x_sample);
         sum_y  += SUM_W'(p.y_sample);
         sum_xy += x * y;
         sum_xx += x * x;
         sum_yy += y * y;
         pair_total++;
      end
      if (p.last_sample) begin
         distance_queue.insert(distance_queue.size(), profile_distance());
         sum_x = '0; sum_y = '0; sum_xy = '0; sum_xx = '0; sum_yy = '0;
         pair_total = 0;
      end
   endtask

   // Offer one request; valid stays up across back-to-back requests.
   task automatic send_pair(input logic [SAMPLE_BITS-1:0] x,
                            input logic [SAMPLE_BITS-1:0] y, input bit last);
      ppd_req_type p;
      p.x_sample    = x;
      p.y_sample    = y;
      p.last_sample = last;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      track_request(p);
      request_count++;
   endtask

   // Drop valid and wait for every expected result to come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (distance_queue.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  = 0;
         stall_left = 0;
      end else if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      ppd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (distance_queue.size() == 0) begin
            $display("unexpected result: distance %0d status %0d pairs %0d",
                     rsp_payload.distance, rsp_payload.status, rsp_payload.observed_pairs);
            error_count++;
         end else begin
            want = distance_queue.pop_front();
            if (rsp_payload.distance !== want.distance)
               report_mismatch("distance", rsp_payload.distance, want.distance);
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.observed_pairs !== want.observed_pairs)
               report_mismatch("observed_pairs", 32'(rsp_payload.observed_pairs),
                               32'(want.observed_pairs));
         end
         result_count++;
      end
   end

   // One profile of random content; the style picks how x and y relate.
   task automatic send_profile(input int len, input int style);
      logic [SAMPLE_BITS-1:0] x, y;
      int skip_pct;
      skip_pct = $urandom_range(0, 30);
      for (int i = 0; i < len; i++) begin
         case (style)
            0: begin
               x = SAMPLE_BITS'($urandom);
               y = SAMPLE_BITS'($urandom);
            end
            1: begin
               x = SAMPLE_BITS'($urandom_range(0, 3));
               y = SAMPLE_BITS'($urandom_range(1, 3));
            end
            2: begin
               x = SAMPLE_BITS'($urandom);
               y = SAMPLE_BITS'(x + $urandom_range(0, 255));
            end
            3: begin
               x = SAMPLE_BITS'($urandom);
               y = SAMPLE_MAX - x;
            end
            default: begin
               x = 24'h5A5A5A;
               y = SAMPLE_BITS'($urandom);
            end
         endcase
         if (y == 0) y = 1;
         if ($urandom_range(0, 99) < skip_pct) y = '0;
         send_pair(x, y, i == len - 1);
      end
   endtask

   // Extremes and every special case, at most a couple dozen requests.
   task automatic test_directed();
      send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);        // one pair: too few
      send_pair(24'd7, '0, 1'b1);                     // nothing observed
      send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);        // equal x: degenerate
      send_pair(SAMPLE_MAX, 24'd1, 1'b1);
      send_pair('0, 24'd1, 1'b0);                     // perfect positive
      send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
      send_pair('0, SAMPLE_MAX, 1'b0);                // negative correlation
      send_pair(24'd1000, 24'd500, 1'b0);
      send_pair(SAMPLE_MAX, 24'd1, 1'b1);
      send_pair(24'd3, 24'd9, 1'b0);                  // last pair skipped
      send_pair(24'd8, 24'd2, 1'b0);
      send_pair(24'd5, 24'd4, 1'b0);
      send_pair(SAMPLE_MAX, '0, 1'b1);
      send_pair(24'h800000, 24'h000001, 1'b0);        // alternating bit patterns
      send_pair(24'h555555, 24'hAAAAAA, 1'b0);
      send_pair(24'hAAAAAA, 24'h555555, 1'b1);
      drain();
   endtask

   // Result path held off long while the sender keeps offering.
   task automatic test_backpressure();
      hold_len = 2500;
      for (int i = 0; i < 4; i++) send_profile($urandom_range(3, 8), i % 4);
      drain();
   endtask

   // Bulk random profiles; mostly well formed, some of only one or two requests, or empty noise.
   task automatic test_random(input int budget);
      int start, len;
      start = request_count;
      while (request_count - start < budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
         send_profile(len, $urandom_range(0, 4));
      end
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      idle_enable = 1'b1;
      hold_len    = 0;
      error_count = 0;
      request_count = 0;
      result_count  = 0;
      sum_x = '0; sum_y = '0; sum_xy = '0; sum_xx = '0; sum_yy = '0;
      pair_total = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(1600);
      idle_enable = 1'b0;                              // closing stretch at full rate
      test_random(300);
      repeat (50) @(posedge clock);

      $display("covered %0d requests and %0d distance results, with stalls, a long",
               request_count, result_count);
      $display("result hold-off, skipped and short profiles and the special cases");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
